// ----- sv/bge_pkg.sv -----
// bitmap group encoder: shared types, constants and helper functions
// used by the lane, merge, packer and top-level modules; no dependencies
`default_nettype none

package bge_pkg;

    // row geometry and the cap on held white codes
    localparam int MAX_ROW_WIDTH = 1024;
    localparam int WHITE_CAP_INT = ((MAX_ROW_WIDTH / 4 - 1) < 255) ? (MAX_ROW_WIDTH / 4 - 1) : 255;
    localparam logic [7:0] WHITE_CAP = 8'(WHITE_CAP_INT);

    // group shape
    localparam int LANES = 4;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam logic [2:0] GROUP_FULL = 3'(LANES);

    // pixel values with a short code
    localparam logic [7:0] PIX_WHITE = 8'hFF;
    localparam logic [7:0] PIX_BLACK = 8'h00;

    // code prefixes
    localparam logic [7:0] PREFIX_ZERO  = 8'h00;
    localparam logic [7:0] PREFIX_BLACK = 8'h02;
    localparam logic [7:0] PREFIX_RAW   = 8'h03;

    // result kinds
    localparam logic KIND_CODE = 1'b0;
    localparam logic KIND_FLAG = 1'b1;

    // per-lane pixel findings
    typedef struct packed {
        logic blank;
        logic dark;
    } lane_flags_t;

    // group class, independent of row state
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_WHITE,
        CLS_BLACK,
        CLS_SHORT_WHITE,
        CLS_RAW
    } grp_class_t;

    // merged group description handed to the packer
    typedef struct packed {
        grp_class_t cls;
        logic [2:0] len;
        logic       ends_row;
        logic       ends_image;
    } grp_info_t;

    // code operation chosen at accept time
    typedef enum logic [1:0] {
        OP_NONE,
        OP_ZERO,
        OP_BLACK,
        OP_RAW
    } code_op_t;

    // packer sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WHITES,
        ST_PREFIX,
        ST_BYTES,
        ST_FLUSH,
        ST_FLAG,
        ST_DONE
    } eng_state_t;

    // group length with oversize values limited to a full group
    function automatic logic [2:0] grp_len_clamp(input logic [2:0] len);
        logic [2:0] res;
        res = (len > GROUP_FULL) ? GROUP_FULL : len;
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bge_lane.sv -----
// bitmap group encoder: one pixel lane, tests its pixel for white and black
// depends on bge_pkg
`default_nettype none

module bge_lane (
    input  wire logic [7:0]          pixel,
    input  wire logic                lane_valid,
    output bge_pkg::lane_flags_t     flags
);

    // an unused lane agrees with every class
    always_comb begin
        flags.blank = !lane_valid || (pixel == bge_pkg::PIX_WHITE);
        flags.dark  = !lane_valid || (pixel == bge_pkg::PIX_BLACK);
    end

endmodule

`default_nettype wire

// ----- sv/bge_merge.sv -----
// bitmap group encoder: merges lane findings into one group class
// depends on bge_pkg
`default_nettype none

module bge_merge (
    input  wire bge_pkg::lane_flags_t [bge_pkg::LANES-1:0] flags,
    input  wire logic [2:0]                                group_len,
    input  wire logic                                      row_end,
    input  wire logic                                      image_end,
    output bge_pkg::grp_info_t                             info
);

    logic       all_blank;
    logic       all_dark;
    logic [2:0] len_c;

    // reduce lane flags
    always_comb begin
        all_blank = 1'b1;
        all_dark  = 1'b1;
        for (int i = 0; i < bge_pkg::LANES; i++) begin
            all_blank = all_blank & flags[i].blank;
            all_dark  = all_dark & flags[i].dark;
        end
    end

    assign len_c = bge_pkg::grp_len_clamp(group_len);

    // classify and decide whether the row ends here
    always_comb begin
        info.len        = len_c;
        info.ends_image = image_end;
        info.ends_row   = row_end || image_end || (len_c != bge_pkg::GROUP_FULL);
        priority if (len_c == 3'd0) begin
            info.cls = bge_pkg::CLS_NONE;
        end else if (len_c == bge_pkg::GROUP_FULL && all_blank) begin
            info.cls = bge_pkg::CLS_WHITE;
        end else if (len_c == bge_pkg::GROUP_FULL && all_dark) begin
            info.cls = bge_pkg::CLS_BLACK;
        end else if (all_blank) begin
            info.cls = bge_pkg::CLS_SHORT_WHITE;
        end else begin
            info.cls = bge_pkg::CLS_RAW;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bge_pack.sv -----
// bitmap group encoder: bit packer, white-run release, row flags and output stage
// depends on bge_pkg
`default_nettype none

module bge_pack (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire bge_pkg::grp_info_t                     info,
    input  wire logic [bge_pkg::LANES-1:0][7:0]         pix,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [7:0]                                  m_tdata,
    output logic                                        m_tuser,
    output logic                                        m_tlast
);

    bge_pkg::eng_state_t                  state_reg, state_next;
    bge_pkg::code_op_t                    op_reg, op_in;
    bge_pkg::grp_info_t                   info_reg;
    logic [bge_pkg::LANES-1:0][7:0]       pix_reg;
    logic [7:0]                           accum_reg, accum_next;
    logic [2:0]                           fill_reg, fill_next;
    logic [7:0]                           pend_reg, pend_next;
    logic                                 coded_reg, coded_next;
    logic [bge_pkg::LANE_IDX_W-1:0]       cnt_reg, cnt_next;
    logic                                 hold_valid_reg;
    logic                                 hold_kind_reg;
    logic [7:0]                           hold_value_reg;
    logic                                 out_valid_reg;
    logic                                 out_kind_reg;
    logic [7:0]                           out_value_reg;
    logic                                 out_last_reg;

    logic                                 accept;
    logic                                 out_free;
    logic                                 count_white;
    logic                                 push;
    logic                                 push_kind;
    logic [7:0]                           push_value;
    logic                                 finish;
    logic                                 put_en;
    logic [3:0]                           put_n;
    logic [7:0]                           put_p;
    logic [3:0]                           put_sum;
    logic [4:0]                           put_shift;
    logic [15:0]                          put_word;
    logic [3:0]                           gap;
    logic [bge_pkg::LANE_IDX_W-1:0]       last_idx;

    assign in_ready = (state_reg == bge_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || m_tready;
    assign last_idx = bge_pkg::LANE_IDX_W'(info_reg.len - 3'd1);

    // pick the code operation from the group class and the row state
    always_comb begin
        count_white = 1'b0;
        unique case (info.cls)
            bge_pkg::CLS_WHITE: begin
                op_in       = coded_reg ? bge_pkg::OP_ZERO : bge_pkg::OP_NONE;
                count_white = !coded_reg;
            end
            bge_pkg::CLS_BLACK:       op_in = bge_pkg::OP_BLACK;
            bge_pkg::CLS_SHORT_WHITE: op_in = coded_reg ? bge_pkg::OP_RAW : bge_pkg::OP_NONE;
            bge_pkg::CLS_RAW:         op_in = bge_pkg::OP_RAW;
            default:                  op_in = bge_pkg::OP_NONE;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bge_pkg::ST_IDLE: begin
                if (accept) begin
                    if (op_in == bge_pkg::OP_BLACK || op_in == bge_pkg::OP_RAW) begin
                        state_next = bge_pkg::ST_WHITES;
                    end else if (op_in == bge_pkg::OP_ZERO) begin
                        state_next = bge_pkg::ST_PREFIX;
                    end else begin
                        state_next = bge_pkg::ST_FLUSH;
                    end
                end
            end
            bge_pkg::ST_WHITES: begin
                if (out_free && pend_reg == 8'd0) begin
                    state_next = bge_pkg::ST_PREFIX;
                end
            end
            bge_pkg::ST_PREFIX: begin
                if (out_free) begin
                    state_next = (op_reg == bge_pkg::OP_RAW) ? bge_pkg::ST_BYTES
                                                             : bge_pkg::ST_FLUSH;
                end
            end
            bge_pkg::ST_BYTES: begin
                if (out_free && cnt_reg == last_idx) begin
                    state_next = bge_pkg::ST_FLUSH;
                end
            end
            bge_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = info_reg.ends_row ? bge_pkg::ST_FLAG : bge_pkg::ST_DONE;
                end
            end
            bge_pkg::ST_FLAG: begin
                if (out_free) begin
                    state_next = bge_pkg::ST_DONE;
                end
            end
            bge_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bge_pkg::ST_IDLE;
                end
            end
            default: state_next = bge_pkg::ST_IDLE;
        endcase
    end

    // datapath actions per state
    always_comb begin
        accum_next = accum_reg;
        fill_next  = fill_reg;
        pend_next  = pend_reg;
        coded_next = coded_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        push_kind  = bge_pkg::KIND_CODE;
        push_value = accum_reg;
        finish     = 1'b0;
        put_en     = 1'b0;
        put_n      = 4'd0;
        put_p      = 8'h00;
        gap        = 4'd8 - {1'b0, fill_reg};
        put_sum    = 4'd0;
        put_shift  = 5'd0;
        put_word   = 16'h0000;
        unique case (state_reg)
            bge_pkg::ST_IDLE: begin
                if (accept && count_white && pend_reg < bge_pkg::WHITE_CAP) begin
                    pend_next = pend_reg + 8'd1;
                end
            end
            bge_pkg::ST_WHITES: begin
                // zeros are already in place, only the fill advances
                if (out_free && pend_reg != 8'd0) begin
                    if ({4'd0, gap} <= pend_reg) begin
                        push       = 1'b1;
                        push_value = accum_reg;
                        accum_next = 8'h00;
                        fill_next  = 3'd0;
                        pend_next  = pend_reg - {4'd0, gap};
                    end else begin
                        fill_next = fill_reg + pend_reg[2:0];
                        pend_next = 8'd0;
                    end
                end
            end
            bge_pkg::ST_PREFIX: begin
                if (out_free) begin
                    put_en   = 1'b1;
                    cnt_next = '0;
                    unique case (op_reg)
                        bge_pkg::OP_BLACK: begin
                            put_n      = 4'd2;
                            put_p      = bge_pkg::PREFIX_BLACK;
                            coded_next = 1'b1;
                        end
                        bge_pkg::OP_RAW: begin
                            put_n      = 4'd2;
                            put_p      = bge_pkg::PREFIX_RAW;
                            coded_next = 1'b1;
                        end
                        default: begin
                            put_n = 4'd1;
                            put_p = bge_pkg::PREFIX_ZERO;
                        end
                    endcase
                end
            end
            bge_pkg::ST_BYTES: begin
                if (out_free) begin
                    put_en   = 1'b1;
                    put_n    = 4'd8;
                    put_p    = pix_reg[cnt_reg];
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bge_pkg::ST_FLUSH: begin
                if (out_free && info_reg.ends_image && fill_reg != 3'd0) begin
                    push       = 1'b1;
                    push_value = accum_reg;
                    accum_next = 8'h00;
                    fill_next  = 3'd0;
                end
            end
            bge_pkg::ST_FLAG: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_kind  = bge_pkg::KIND_FLAG;
                    push_value = {7'd0, coded_reg};
                    coded_next = 1'b0;
                    pend_next  = 8'd0;
                end
            end
            bge_pkg::ST_DONE: begin
                finish = out_free;
            end
            default: begin
            end
        endcase

        // append put_n bits of put_p behind the held bits
        if (put_en) begin
            put_sum   = {1'b0, fill_reg} + put_n;
            put_shift = 5'd16 - {2'd0, fill_reg} - {1'b0, put_n};
            put_word  = {accum_reg, 8'h00} | ({8'h00, put_p} << put_shift);
            if (put_sum >= 4'd8) begin
                push       = 1'b1;
                push_value = put_word[15:8];
                accum_next = put_word[7:0];
                fill_next  = 3'(put_sum - 4'd8);
            end else begin
                accum_next = put_word[15:8];
                fill_next  = put_sum[2:0];
            end
        end
    end

    // control and packing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bge_pkg::ST_IDLE;
            accum_reg <= 8'h00;
            fill_reg  <= 3'd0;
            pend_reg  <= 8'd0;
            coded_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            accum_reg <= accum_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
            coded_reg <= coded_next;
        end
    end

    // captured group and byte index
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (accept) begin
            op_reg   <= op_in;
            info_reg <= info;
            pix_reg  <= pix;
        end
    end

    // one-result hold slot so the last flag is known before a result leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (push) begin
                hold_valid_reg <= 1'b1;
                hold_kind_reg  <= push_kind;
                hold_value_reg <= push_value;
            end else if (finish) begin
                hold_valid_reg <= 1'b0;
            end
            if ((push || finish) && hold_valid_reg) begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= hold_kind_reg;
                out_value_reg <= hold_value_reg;
                out_last_reg  <= finish;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/bitmap_group_encoder_top.sv -----
// bitmap group encoder top level: four pixel lanes, merge stage and bit packer
// depends on bge_pkg, bge_lane, bge_merge, bge_pack
//
// Usage: each transfer on the s_ channel carries one group of up to four 8-bit
// pixels of a row; s_tlast marks the group that ends the row, s_tuser marks
// the group that ends the image. Each transfer on the m_ channel is one
// result: a packed code byte (m_tuser 0) or a row flag (m_tuser 1, data 0 for
// an all-white row, 1 for a coded row); m_tlast marks the last result of a
// group. Groups are classified by four parallel lanes in the accept cycle; the
// packer then handles one group at a time and takes one step per cycle: one
// per raw pixel byte, one for the prefix, one for the white release, plus
// flush, row flag and close steps. A released white run adds one release
// step per code byte it completes and one more if it ends inside a byte.
// A result waits in a one-entry hold slot until the next result is made or
// the group closes, and shows on m_ the cycle after; the last result of a
// group shows in the same cycle that s_tready rises again. When the receiver
// stalls, the packer stops stepping and s_tready stays low until the group is
// done. Synchronous reset clears the bit accumulator, the held white count,
// the row state and both output slots.
`default_nettype none

module bitmap_group_encoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // pixel_a, pixel_b, pixel_c, pixel_d, group_len, zero pad
    input  wire logic        s_tuser,   // image_end
    input  wire logic        s_tlast,   // row_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_value
    output logic             m_tuser,   // out_kind
    output logic             m_tlast    // last
);

    logic [bge_pkg::LANES-1:0][7:0]            pix;
    logic [2:0]                                len_c;
    bge_pkg::lane_flags_t [bge_pkg::LANES-1:0] flags;
    bge_pkg::grp_info_t                        info;

    // unpack pixels from the data word
    assign pix   = s_tdata[bge_pkg::LANES*8-1:0];
    assign len_c = bge_pkg::grp_len_clamp(s_tdata[34:32]);

    // one lane per pixel
    for (genvar i = 0; i < bge_pkg::LANES; i++) begin : g_lane
        bge_lane u_lane (
            .pixel      (pix[i]),
            .lane_valid (3'(i) < len_c),
            .flags      (flags[i])
        );
    end

    // combine lane findings
    bge_merge u_merge (
        .flags     (flags),
        .group_len (s_tdata[34:32]),
        .row_end   (s_tlast),
        .image_end (s_tuser),
        .info      (info)
    );

    // packing sequencer and output stage
    bge_pack u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .info     (info),
        .pix      (pix),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- bench/bitmap_group_encoder_top_tb.sv -----
// self-checking testbench for bitmap_group_encoder_top: pixel groups go in on the
// s_ stream, code bytes and row flags are predicted and compared on the m_ stream
// depends on bge_pkg and the bitmap group encoder rtl
`default_nettype none

module bitmap_group_encoder_top_tb;

    // row flag values
    localparam logic [7:0] FLAG_ALL_WHITE = 8'h00;
    localparam logic [7:0] FLAG_CODED     = 8'h01;

    // cycles with no transfer on either side before the run is abandoned
    localparam int QUIET_LIMIT = 3000;
    // settle time after the last expected result
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_WHITE_RUN = 258;

    // one expected result of the encoder
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } enc_result_t;

    // bit-exact encoder state plus the queue of results still owed by the block
    class encoder_scoreboard;
        bit [7:0] code_acc;
        bit [2:0] code_fill;
        bit [7:0] held_whites;
        bit       row_coded;
        enc_result_t awaited[$];
        int errors;
        int n_groups;
        int n_codes;
        int n_flags;

        function int pending();
            return awaited.size();
        endfunction

        function void push_result(bit kind, bit [7:0] value);
            enc_result_t r;
            r.kind  = kind;
            r.value = value;
            r.last  = 1'b0;
            awaited.insert(awaited.size(), r);
        endfunction

        // code bits fill the byte from the msb down
        function void shift_in_bit(bit b);
            code_acc[3'd7 - code_fill] = b;
            if (code_fill == 3'd7) begin
                push_result(bge_pkg::KIND_CODE, code_acc);
                code_acc  = '0;
                code_fill = '0;
            end else begin
                code_fill++;
            end
        endfunction

        function void shift_in_byte(bit [7:0] v);
            for (int i = 7; i >= 0; i--)
                shift_in_bit(v[i]);
        endfunction

        function void release_held_whites();
            for (int i = 0; i < int'(held_whites); i++)
                shift_in_bit(1'b0);
            held_whites = '0;
        endfunction

        // accepted group: work out every result it causes
        function void note_group(bit [39:0] data, bit row_end, bit image_end);
            bit [7:0] pix [4];
            bit [2:0] len;
            bit ends_row;
            bit all_white;
            bit all_black;
            int queued_at_start;
            enc_result_t tail;
            queued_at_start = awaited.size();
            n_groups++;
            for (int i = 0; i < 4; i++)
                pix[i] = data[8*i +: 8];
            len = data[34:32];
            if (len > bge_pkg::GROUP_FULL)
                len = bge_pkg::GROUP_FULL;
            ends_row = row_end || image_end || (len < bge_pkg::GROUP_FULL);
            all_white = 1'b1;
            all_black = 1'b1;
            for (int i = 0; i < int'(len); i++) begin
                if (pix[i] != bge_pkg::PIX_WHITE)
                    all_white = 1'b0;
                if (pix[i] != bge_pkg::PIX_BLACK)
                    all_black = 1'b0;
            end

            // an empty group gives no code at all
            if (len != 0) begin
                if (len == bge_pkg::GROUP_FULL && all_white) begin
                    if (row_coded)
                        shift_in_bit(1'b0);
                    else if (held_whites < bge_pkg::WHITE_CAP)
                        held_whites++;
                end else if (len == bge_pkg::GROUP_FULL && all_black) begin
                    release_held_whites();
                    shift_in_bit(1'b1);
                    shift_in_bit(1'b0);
                    row_coded = 1'b1;
                end else if (!(all_white && !row_coded)) begin
                    // raw group; a short white tail of an uncoded row is dropped instead
                    release_held_whites();
                    shift_in_bit(1'b1);
                    shift_in_bit(1'b1);
                    for (int i = 0; i < int'(len); i++)
                        shift_in_byte(pix[i]);
                    row_coded = 1'b1;
                end
            end

            // partial byte flush at image end
            if (image_end && code_fill != 0) begin
                push_result(bge_pkg::KIND_CODE, code_acc);
                code_acc  = '0;
                code_fill = '0;
            end

            if (ends_row) begin
                push_result(bge_pkg::KIND_FLAG, row_coded ? FLAG_CODED : FLAG_ALL_WHITE);
                row_coded   = 1'b0;
                held_whites = '0;
            end

            // mark the final result of this group
            if (awaited.size() > queued_at_start) begin
                tail = awaited.pop_back();
                tail.last = 1'b1;
                awaited.insert(awaited.size(), tail);
            end
        endfunction

        function void report(string field, int exp_v, int got_v);
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v,
                         got_v);
        endfunction

        // result transfer: compare with the oldest expectation
        function void check_result(bit [7:0] value, bit kind, bit last);
            enc_result_t exp_r;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result: expected none, actual kind %0d value %0h last %0d",
                             $time, kind, value, last);
                return;
            end
            exp_r = awaited.pop_front();
            if (kind == bge_pkg::KIND_FLAG)
                n_flags++;
            else
                n_codes++;
            if (kind !== exp_r.kind)
                report("kind", exp_r.kind, kind);
            if (value !== exp_r.value)
                report("value", exp_r.value, value);
            if (last !== exp_r.last)
                report("last", exp_r.last, last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int tx_idle_pct = 16;
    int rx_idle_pct = 78;
    int groups_sent = 0;
    int quiet_cycles = 0;
    encoder_scoreboard sb;

    bitmap_group_encoder_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // monitors: note accepted groups, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_group(s_tdata, s_tlast, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one group transfer, with random idle cycles ahead of it
    task automatic send_group(input bit [7:0] pa, input bit [7:0] pb, input bit [7:0] pc,
                              input bit [7:0] pd, input bit [2:0] len, input bit row_end,
                              input bit image_end);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, len, pd, pc, pb, pa};
        s_tlast  <= row_end;
        s_tuser  <= image_end;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        groups_sent++;
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic bit [7:0] rand_pixel();
        int r;
        r = $urandom_range(3);
        if (r == 0)
            return bge_pkg::PIX_WHITE;
        else if (r == 1)
            return bge_pkg::PIX_BLACK;
        return 8'($urandom_range(255));
    endfunction

    // well-formed row: full groups, possibly a short last group
    task automatic send_row(input int ngroups, input bit img_end);
        bit [7:0] p [4];
        bit [2:0] len;
        bit last_g;
        int style;
        int r;
        style = $urandom_range(99);
        for (int g = 0; g < ngroups; g++) begin
            last_g = (g == ngroups - 1);
            len = bge_pkg::GROUP_FULL;
            if (last_g && $urandom_range(2) == 0)
                len = 3'($urandom_range(1, 3));
            r = $urandom_range(99);
            for (int i = 0; i < 4; i++) begin
                if (style < 20 || r < 40)
                    p[i] = bge_pkg::PIX_WHITE;
                else if (r < 60)
                    p[i] = bge_pkg::PIX_BLACK;
                else
                    p[i] = rand_pixel();
            end
            // near miss of a white group
            if (style >= 20 && r >= 60 && r < 70) begin
                p = '{bge_pkg::PIX_WHITE, bge_pkg::PIX_WHITE, bge_pkg::PIX_WHITE,
                      bge_pkg::PIX_WHITE};
                p[$urandom_range(3)] = 8'($urandom_range(255));
            end
            send_group(p[0], p[1], p[2], p[3], len, last_g, last_g && img_end);
        end
    endtask

    // arbitrary group, any length code and any flags
    task automatic send_noise();
        send_group(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(),
                   3'($urandom_range(7)), 1'($urandom_range(1)), ($urandom_range(9) == 0));
    endtask

    task automatic random_phase(input int ngroups);
        int target;
        target = groups_sent + ngroups;
        while (groups_sent < target) begin
            if ($urandom_range(9) < 8)
                send_row($urandom_range(1, 10), ($urandom_range(6) == 0));
            else
                send_noise();
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corner groups
        send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0);
        send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1, 1'b0);
        send_group(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b1, 1'b0);
        send_group(8'h00, 8'hFF, 8'h80, 8'h7F, 3'd4, 1'b0, 1'b0);
        send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0);
        send_group(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0, 1'b0);
        // short group without row end still closes the row
        send_group(8'h5A, 8'hFF, 8'h00, 8'h11, 3'd1, 1'b0, 1'b0);
        // empty group, also closes the row
        send_group(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0, 1'b0);
        // short white tail of an all-white row is dropped
        send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0);
        send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0);
        send_group(8'hFF, 8'hFF, 8'h12, 8'h34, 3'd2, 1'b1, 1'b0);
        // held whites released by a black group, then a coded short white tail
        send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0);
        send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0);
        send_group(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0, 1'b0);
        send_group(8'hFF, 8'hFF, 8'hFF, 8'h00, 3'd3, 1'b1, 1'b0);
        // oversize lengths act as full groups
        send_group(8'h01, 8'h02, 8'h03, 8'h04, 3'd5, 1'b0, 1'b0);
        send_group(8'h00, 8'h00, 8'h00, 8'h00, 3'd6, 1'b0, 1'b0);
        send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 1'b0, 1'b0);
        // image end without row end
        send_group(8'hC3, 8'h3C, 8'hA5, 8'h5A, 3'd4, 1'b0, 1'b1);
        send_group(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 1'b1);
        send_group(8'hFF, 8'hFF, 8'hFF, 8'h00, 3'd4, 1'b0, 1'b0);
        send_group(8'h00, 8'h00, 8'h00, 8'h01, 3'd4, 1'b1, 1'b1);
        send_group(8'h80, 8'h80, 8'h80, 8'h80, 3'd4, 1'b0, 1'b0);
        send_group(8'h7F, 8'h80, 8'hFF, 8'hEE, 3'd3, 1'b1, 1'b0);

        // slow receiver
        random_phase(110);
        wait_drained();

        // slow sender
        tx_idle_pct = 78;
        rx_idle_pct = 16;
        random_phase(110);
        wait_drained();

        // full rate, one white run long enough to saturate the held count
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < LONG_WHITE_RUN; i++)
            send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0);
        send_group(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b1, 1'b1);
        random_phase(40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d groups; checked %0d code bytes and %0d row flags",
                 groups_sent, sb.n_codes, sb.n_flags);
        $display("covered corner groups, random rows under three stall mixes, a saturated white run");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
